>>> src/hprf_pkg.sv
// ----------------------------------------------------------------------------
// HTTP POST request framer package
// Shared codes, text constants and defaults for the request framer.
// ----------------------------------------------------------------------------
package hprf_pkg;

   localparam int DEFAULT_CONNECTIONS = 16;
   localparam int DEFAULT_COUNT_WIDTH = 16;
   localparam int METHOD_LEN = 8;
   localparam int PATTERN_LEN = 16;
   localparam logic [15:0] MAX_REQUEST_RESET = 16'd4096;

   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_LF = 8'h0a;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef enum logic [1:0] {
      OP_DATA  = 2'd0,
      OP_OPEN  = 2'd1,
      OP_CLOSE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_BODY   = 2'd0,
      KIND_EMPTY  = 2'd1,
      KIND_METHOD = 2'd2,
      KIND_LONG   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_METHOD = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2,
      PH_DROP   = 2'd3
   } phase_type;

   function automatic logic [7:0] method_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = "P";
         3'd1: c = "O";
         3'd2: c = "S";
         3'd3: c = "T";
         3'd4: c = " ";
         3'd5: c = "/";
         3'd6: c = "o";
         3'd7: c = "m";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] pattern_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:  c = "C";
         4'd1:  c = "o";
         4'd2:  c = "n";
         4'd3:  c = "t";
         4'd4:  c = "e";
         4'd5:  c = "n";
         4'd6:  c = "t";
         4'd7:  c = "-";
         4'd8:  c = "L";
         4'd9:  c = "e";
         4'd10: c = "n";
         4'd11: c = "g";
         4'd12: c = "t";
         4'd13: c = "h";
         4'd14: c = ":";
         4'd15: c = " ";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> src/hprf_slot_ram.sv
// ----------------------------------------------------------------------------
// Slot state memory
// One write port, one registered read port, write data forwarded to the read
// register when both hit the same entry at the same edge.
// ----------------------------------------------------------------------------
module hprf_slot_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/http_post_request_framer.sv
// ----------------------------------------------------------------------------
// HTTP POST request framer
// Frames POST requests byte by byte over a set of connection slots.
// ----------------------------------------------------------------------------
// Input channel req_*: one event per transfer (data byte, open or close of a
// slot). Result channel rsp_*: at most one result per event (body byte with
// last mark, empty body done, wrong method, too long). csr_wr_en/csr_wr_data
// write max_request_bytes; write it only while the block is idle.
// Per-slot framing state lives in a one-port-read, one-port-write memory.
// An event is read from the memory at its transfer, updated in the update
// stage and written back; a hit on the entry being written is forwarded.
// A result goes from its input transfer through the update stage into the
// result register, which drives rsp_*.
// Throughput: one event per cycle when no result stalls, set by the
// read-modify-write loop on the slot memory.
// The result register holds a result until it is taken; while it is full
// and not taken, an event with a result waits in the update stage and
// req_ready drops; events without a result still pass.
// Reset (synchronous) marks all slots inactive, empties the pipeline and
// sets max_request_bytes to 4096. No clearing pass is needed: a slot's
// memory entry is written when the slot is opened.
// ----------------------------------------------------------------------------
module http_post_request_framer
   import hprf_pkg::*;
#(
   parameter int CONNECTIONS = DEFAULT_CONNECTIONS,
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [3:0]  req_connection,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_result_connection,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_body_byte,
   output logic        rsp_last,
   output logic [15:0] rsp_body_length,

   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int CW = COUNT_WIDTH;
   localparam int SLOT_AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
   localparam int CMP_W = (CW > 16) ? CW : 16;
   localparam logic [CW-1:0] COUNT_MAX = '1;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  method_matched;
      logic [4:0]  pattern_matched;
      logic        digits_active;
      logic        length_known;
      logic [CW-1:0] content_length;
      logic [1:0]  crlf_progress;
      logic [CW-1:0] request_bytes;
      logic [CW-1:0] body_left;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   // configuration
   logic [15:0] max_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_REQUEST_RESET;
      end else if (csr_wr_en) begin
         max_bytes_ff <= csr_wr_data;
      end
   end

   // accept stage
   logic               req_fire;
   logic [31:0]        req_conn_ext;
   logic [SLOT_AW-1:0] req_addr;
   logic               req_in_range;

   assign req_fire     = req_valid && req_ready;
   assign req_conn_ext = 32'(req_connection);
   assign req_addr     = req_conn_ext[SLOT_AW-1:0];
   assign req_in_range = (req_conn_ext < 32'(CONNECTIONS));

   // update stage
   logic               s1_valid_ff;
   op_type             s1_op_ff;
   logic [3:0]         s1_conn_ff;
   logic [7:0]         s1_byte_ff;
   logic [SLOT_AW-1:0] s1_addr_ff;
   logic               s1_in_range_ff;

   logic [CONNECTIONS-1:0] active_ff;
   logic [CONNECTIONS-1:0] active_in;

   slot_type slot_rd;
   slot_type slot_wr;
   logic     slot_we;
   logic [SLOT_W-1:0] slot_rd_bits;

   logic       s1_emit;
   kind_type   s1_kind;
   logic [7:0] s1_out_byte;
   logic       s1_out_last;
   logic [15:0] s1_out_len;
   logic       s1_write;
   logic       s1_done;
   logic       out_free;

   logic [CW+3:0] scaled;
   logic [2:0]    crlf_next;
   logic [4:0]    p_next;
   logic [31:0]   len32;
   logic          hdr_length_known;
   logic [CW-1:0] hdr_length;
   logic [CW-1:0] left_next;

   hprf_slot_ram #(
      .DEPTH (CONNECTIONS),
      .AW    (SLOT_AW),
      .WIDTH (SLOT_W)
   ) u_slot_ram (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .rd_data (slot_rd_bits),
      .wr_en   (slot_we),
      .wr_addr (s1_addr_ff),
      .wr_data (slot_wr)
   );

   assign slot_rd = slot_type'(slot_rd_bits);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff       <= op_type'(req_operation);
         s1_conn_ff     <= req_connection;
         s1_byte_ff     <= req_data_byte;
         s1_addr_ff     <= req_addr;
         s1_in_range_ff <= req_in_range;
      end
   end

   always_comb begin
      slot_wr          = slot_rd;
      s1_emit          = 1'b0;
      s1_write         = 1'b0;
      s1_kind          = KIND_BODY;
      s1_out_byte      = 8'h00;
      s1_out_last      = 1'b0;
      len32            = 32'(slot_rd.content_length);
      s1_out_len       = len32[15:0];
      scaled           = '0;
      crlf_next        = '0;
      p_next           = '0;
      hdr_length_known = slot_rd.length_known;
      hdr_length       = slot_rd.content_length;
      left_next        = slot_rd.body_left;
      active_in        = active_ff;

      if (s1_valid_ff && s1_in_range_ff) begin
         case (s1_op_ff)
            OP_OPEN: begin
               slot_wr = '0;
               s1_write = 1'b1;
               active_in[s1_addr_ff] = 1'b1;
            end
            OP_CLOSE: begin
               active_in[s1_addr_ff] = 1'b0;
            end
            OP_DATA: begin
               if (active_ff[s1_addr_ff] && (slot_rd.phase != PH_DROP)) begin
                  s1_write = 1'b1;
                  if (CMP_W'(slot_rd.request_bytes) >= CMP_W'(max_bytes_ff)) begin
                     slot_wr.phase = PH_DROP;
                     s1_emit = 1'b1;
                     s1_kind = KIND_LONG;
                  end else begin
                     if (slot_rd.request_bytes != COUNT_MAX) begin
                        slot_wr.request_bytes = slot_rd.request_bytes + CW'(1);
                     end
                     case (slot_rd.phase)
                        PH_METHOD: begin
                           if (slot_rd.method_matched[3] ||
                               (s1_byte_ff != method_char(slot_rd.method_matched[2:0])))
                           begin
                              slot_wr.phase = PH_DROP;
                              s1_emit = 1'b1;
                              s1_kind = KIND_METHOD;
                           end else begin
                              slot_wr.method_matched = slot_rd.method_matched + 4'd1;
                              if (slot_rd.method_matched == 4'(METHOD_LEN - 1)) begin
                                 slot_wr.phase = PH_HEADER;
                              end
                           end
                        end
                        PH_HEADER: begin
                           if (slot_rd.digits_active) begin
                              if ((s1_byte_ff >= CHAR_ZERO) && (s1_byte_ff <= CHAR_NINE)) begin
                                 scaled = ((CW+4)'(slot_rd.content_length) << 3)
                                        + ((CW+4)'(slot_rd.content_length) << 1)
                                        + (CW+4)'(s1_byte_ff - CHAR_ZERO);
                                 if (scaled > (CW+4)'(COUNT_MAX)) begin
                                    hdr_length = COUNT_MAX;
                                 end else begin
                                    hdr_length = scaled[CW-1:0];
                                 end
                              end else begin
                                 slot_wr.digits_active = 1'b0;
                              end
                           end else if (!slot_rd.length_known) begin
                              if (!slot_rd.pattern_matched[4] &&
                                  (s1_byte_ff == pattern_char(slot_rd.pattern_matched[3:0])))
                              begin
                                 p_next = slot_rd.pattern_matched + 5'd1;
                                 if (p_next == 5'(PATTERN_LEN)) begin
                                    hdr_length_known = 1'b1;
                                    slot_wr.digits_active = 1'b1;
                                    hdr_length = '0;
                                    p_next = '0;
                                 end
                              end else begin
                                 p_next = (s1_byte_ff == pattern_char(4'd0)) ? 5'd1 : 5'd0;
                              end
                              slot_wr.pattern_matched = p_next;
                           end
                           slot_wr.length_known = hdr_length_known;
                           slot_wr.content_length = hdr_length;

                           if (s1_byte_ff == CHAR_CR) begin
                              if ((slot_rd.crlf_progress == 2'd0) ||
                                  (slot_rd.crlf_progress == 2'd2)) begin
                                 crlf_next = 3'(slot_rd.crlf_progress) + 3'd1;
                              end else begin
                                 crlf_next = 3'd1;
                              end
                           end else if ((s1_byte_ff == CHAR_LF) &&
                                        ((slot_rd.crlf_progress == 2'd1) ||
                                         (slot_rd.crlf_progress == 2'd3))) begin
                              crlf_next = 3'(slot_rd.crlf_progress) + 3'd1;
                           end else begin
                              crlf_next = 3'd0;
                           end
                           slot_wr.crlf_progress = crlf_next[1:0];

                           if (crlf_next[2]) begin
                              slot_wr.crlf_progress = 2'd0;
                              slot_wr.digits_active = 1'b0;
                              slot_wr.phase = PH_BODY;
                              if (hdr_length_known) begin
                                 if (hdr_length == '0) begin
                                    slot_wr = '0;
                                    s1_emit = 1'b1;
                                    s1_kind = KIND_EMPTY;
                                    s1_out_last = 1'b1;
                                    s1_out_len = 16'd0;
                                 end else begin
                                    slot_wr.body_left = hdr_length;
                                 end
                              end
                           end
                        end
                        PH_BODY: begin
                           if (slot_rd.length_known) begin
                              if (slot_rd.body_left != '0) begin
                                 left_next = slot_rd.body_left - CW'(1);
                              end
                              slot_wr.body_left = left_next;
                              s1_emit = 1'b1;
                              s1_kind = KIND_BODY;
                              s1_out_byte = s1_byte_ff;
                              if (left_next == '0) begin
                                 s1_out_last = 1'b1;
                                 slot_wr = '0;
                              end
                           end
                        end
                        default: begin
                           s1_write = 1'b0;
                        end
                     endcase
                  end
               end
            end
            default: begin
               s1_write = 1'b0;
            end
         endcase
      end
   end

   assign out_free  = !rsp_valid || rsp_ready;
   assign s1_done   = s1_valid_ff && (!s1_emit || out_free);
   assign req_ready = !s1_valid_ff || s1_done;
   assign slot_we   = s1_done && s1_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (s1_done) begin
         active_ff <= active_in;
      end
   end

   // result register
   logic        rsp_valid_ff;
   logic [3:0]  rsp_conn_ff;
   kind_type    rsp_kind_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;
   logic [15:0] rsp_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_done && s1_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_done && s1_emit) begin
         rsp_conn_ff <= s1_conn_ff;
         rsp_kind_ff <= s1_kind;
         rsp_byte_ff <= s1_out_byte;
         rsp_last_ff <= s1_out_last;
         rsp_len_ff  <= s1_out_len;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_connection = rsp_conn_ff;
   assign rsp_kind              = rsp_kind_ff;
   assign rsp_body_byte         = rsp_byte_ff;
   assign rsp_last              = rsp_last_ff;
   assign rsp_body_length       = rsp_len_ff;

`ifndef ASSERT_OFF
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_EMPTY) |-> rsp_last && (rsp_body_length == 16'd0))
      else $error("empty body result without last mark or with nonzero length");

   a_error_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == KIND_METHOD) || (rsp_kind == KIND_LONG))
      |-> !rsp_last && (rsp_body_byte == 8'h00))
      else $error("error result carries last mark or body byte");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_done |-> !req_ready)
      else $error("input accepted while update stage is stalled");

   a_reset_inactive: assert property (@(posedge clock)
      reset |=> (active_ff == '0) && !rsp_valid && !s1_valid_ff)
      else $error("slots or pipeline not cleared by reset");
`endif

endmodule
